@@ rtl/proximity_gated_audio_conditioner_macros.svh @@
// assertion macros used by the port-level checker file
`ifndef PROXIMITY_GATED_AUDIO_CONDITIONER_MACROS_SVH
`define PROXIMITY_GATED_AUDIO_CONDITIONER_MACROS_SVH

// same-cycle implication, checked outside reset
`define PGAC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define PGAC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/pgac_pkg.sv @@
// package: types, constants and codes of the proximity gated audio conditioner
package pgac_pkg;

  localparam int SAMPLE_BITS   = 10;
  localparam int MAX_THRESHOLD = 400;

  localparam int SLEW_W   = 10;
  localparam int TICKS_W  = 8;
  localparam int CFG_W    = 10;
  localparam int CFG_IDX_W = 1;
  localparam int CMP_W    = (SAMPLE_BITS > SLEW_W) ? SAMPLE_BITS + 1 : SLEW_W + 1;
  localparam int TH_W     = $clog2(MAX_THRESHOLD);
  localparam int LIM_W    = (TH_W + TICKS_W > 16) ? TH_W + TICKS_W : 16;
  localparam int SUM3_W   = SAMPLE_BITS + 2;
  localparam int DIV3_SHIFT = SAMPLE_BITS + 3;
  localparam int DIV3_MUL_W = DIV3_SHIFT - 1;
  localparam int DIV3_MUL   = ((1 << DIV3_SHIFT) + 2) / 3;
  localparam int PROD_W     = SUM3_W + DIV3_MUL_W;

  localparam int QUEUE_DEPTH = 4;
  localparam int QP_W        = $clog2(QUEUE_DEPTH);
  localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

  localparam logic [SLEW_W-1:0]      SLEW_RESET  = SLEW_W'(140);
  localparam logic [TICKS_W-1:0]     TICKS_RESET = TICKS_W'(58);
  localparam logic [TH_W-1:0]        TH_RESET    = TH_W'(10);
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MID  = SAMPLE_BITS'(1 << (SAMPLE_BITS - 1));
  localparam logic [15:0]            FAR_WIDTH   = 16'hFFFF;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SLEW_LIMIT   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_CM = 1'd1;

  // request types
  localparam logic [1:0] REQ_AUDIO = 2'd0;
  localparam logic [1:0] REQ_CMD   = 2'd1;
  localparam logic [1:0] REQ_EDGE  = 2'd2;
  localparam logic [1:0] REQ_TICK  = 2'd3;

  // command byte classes
  localparam logic [2:0] CMD_OTHER  = 3'd0;
  localparam logic [2:0] CMD_IDLE   = 3'd1;
  localparam logic [2:0] CMD_MANUAL = 3'd2;
  localparam logic [2:0] CMD_DIST   = 3'd3;
  localparam logic [2:0] CMD_DIGIT  = 3'd4;
  localparam logic [2:0] CMD_EOL    = 3'd5;

  localparam logic [7:0] CHAR_I  = 8'h49;
  localparam logic [7:0] CHAR_M  = 8'h4D;
  localparam logic [7:0] CHAR_D  = 8'h44;
  localparam logic [7:0] CHAR_0  = 8'h30;
  localparam logic [7:0] CHAR_9  = 8'h39;
  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  // operating modes
  localparam logic [1:0] OP_IDLE   = 2'd0;
  localparam logic [1:0] OP_MANUAL = 2'd1;
  localparam logic [1:0] OP_RANGE  = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] audio_frame;
    logic [7:0]  cmd_byte;
    logic [15:0] edge_time;
  } in_item_t;

  typedef struct packed {
    logic       audio_valid;
    logic [7:0] audio_byte;
    logic       trigger_request;
    logic       led_on;
    logic [1:0] mode_now;
    logic       recording_on;
  } out_item_t;

  typedef struct packed {
    logic [1:0]             kind;
    logic [SAMPLE_BITS-1:0] sample;
    logic [2:0]             cmd;
    logic [3:0]             digit;
    logic [15:0]            edge_time;
  } job_t;

  typedef struct packed {
    logic not_empty;
    logic full;
  } q_stat_t;

endpackage

@@ rtl/proximity_gated_audio_conditioner.sv @@
// top level: proximity gated audio conditioner
//
//   channel  handshake              payload
//   in       in_valid / in_ready    in_data   (req_type, audio_frame, cmd_byte, edge_time)
//   out      out_valid / out_ready  out_data  (one result per input item)
//   cfg      cfg_we                 cfg_index, cfg_data
//
// one item per cycle while not full; back end retires one job per cycle unless out stalls
// result passes through the queue write, then the result register
// in_ready drops only when the four-entry job queue is full
// out stalls hold the result register and let the queue fill behind it
// synchronous active-low reset, no clearing pass
module proximity_gated_audio_conditioner (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  pgac_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output pgac_pkg::out_item_t            out_data,
  input  logic                           cfg_we,
  input  logic [pgac_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pgac_pkg::CFG_W-1:0]     cfg_data
);

  pgac_pkg::job_t    front_job;
  pgac_pkg::job_t    head_job;
  pgac_pkg::q_stat_t q_stat;
  logic              push;
  logic              pop;

  assign in_ready = !q_stat.full;
  assign push     = in_valid && in_ready;

  pgac_front u_front (
    .in_data (in_data),
    .job     (front_job)
  );

  pgac_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (front_job),
    .pop      (pop),
    .head_job (head_job),
    .stat     (q_stat)
  );

  pgac_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_stat    (q_stat),
    .job       (head_job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ rtl/pgac_front.sv @@
// front end: decodes an input item into a job for the queue
module pgac_front (
  input  pgac_pkg::in_item_t in_data,
  output pgac_pkg::job_t     job
);

  logic [2:0] cmd_class;

  always_comb begin
    priority if (in_data.cmd_byte == pgac_pkg::CHAR_I) begin
      cmd_class = pgac_pkg::CMD_IDLE;
    end else if (in_data.cmd_byte == pgac_pkg::CHAR_M) begin
      cmd_class = pgac_pkg::CMD_MANUAL;
    end else if (in_data.cmd_byte == pgac_pkg::CHAR_D) begin
      cmd_class = pgac_pkg::CMD_DIST;
    end else if (in_data.cmd_byte >= pgac_pkg::CHAR_0 &&
                 in_data.cmd_byte <= pgac_pkg::CHAR_9) begin
      cmd_class = pgac_pkg::CMD_DIGIT;
    end else if (in_data.cmd_byte == pgac_pkg::CHAR_CR ||
                 in_data.cmd_byte == pgac_pkg::CHAR_LF) begin
      cmd_class = pgac_pkg::CMD_EOL;
    end else begin
      cmd_class = pgac_pkg::CMD_OTHER;
    end
  end

  always_comb begin
    job.kind      = in_data.req_type;
    job.sample    = in_data.audio_frame[pgac_pkg::SAMPLE_BITS-1:0];
    job.cmd       = cmd_class;
    job.digit     = in_data.cmd_byte[3:0];
    job.edge_time = in_data.edge_time;
  end

endmodule

@@ rtl/pgac_queue.sv @@
// job queue between front and back end
module pgac_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  pgac_pkg::job_t      push_job,
  input  logic                pop,
  output pgac_pkg::job_t      head_job,
  output pgac_pkg::q_stat_t   stat
);

  pgac_pkg::job_t              mem_r [pgac_pkg::QUEUE_DEPTH];
  logic [pgac_pkg::QP_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [pgac_pkg::QP_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [pgac_pkg::QC_W-1:0]   count_r, count_nxt;

  localparam logic [pgac_pkg::QP_W-1:0] LAST_PTR = pgac_pkg::QP_W'(pgac_pkg::QUEUE_DEPTH - 1);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  assign head_job       = mem_r[rd_ptr_r];
  assign stat.not_empty = (count_r != '0);
  assign stat.full      = (count_r == pgac_pkg::QC_W'(pgac_pkg::QUEUE_DEPTH));

endmodule

@@ rtl/pgac_back.sv @@
// back end: filter, command and echo state, registered result
module pgac_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [pgac_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pgac_pkg::CFG_W-1:0]   cfg_data,
  input  pgac_pkg::q_stat_t            q_stat,
  input  pgac_pkg::job_t               job,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output pgac_pkg::out_item_t          out_data
);

  localparam int SB = pgac_pkg::SAMPLE_BITS;

  logic [pgac_pkg::SLEW_W-1:0]  slew_r;
  logic [pgac_pkg::TICKS_W-1:0] ticks_r;

  logic [SB-1:0]   last_r, last_nxt;
  logic [SB-1:0]   older_r, older_nxt;
  logic [SB:0]     pair_sum_r, pair_sum_nxt;
  logic            pair_phase_r, pair_phase_nxt;
  logic [1:0]      mode_r, mode_nxt;
  logic            record_r, record_nxt;
  logic            digits_r, digits_nxt;
  logic [15:0]     pending_r, pending_nxt;
  logic [pgac_pkg::TH_W-1:0] thresh_r, thresh_nxt;
  logic            edge_phase_r, edge_phase_nxt;
  logic [15:0]     rise_r, rise_nxt;
  logic [15:0]     width_r, width_nxt;
  logic            fresh_r, fresh_nxt;
  logic            led_r, led_nxt;

  logic                 out_valid_r;
  pgac_pkg::out_item_t  out_data_r, out_data_nxt;

  logic [pgac_pkg::CMP_W-1:0]      s_ext, last_ext, slew_ext, s_lim;
  logic [SB-1:0]                   s_clamped;
  logic [pgac_pkg::SUM3_W-1:0]     sum3;
  logic [pgac_pkg::PROD_W-1:0]     prod;
  logic [SB-1:0]                   avg;
  logic [SB:0]                     pair_total;
  logic [SB-1:0]                   pavg;
  logic [15:0]                     pending_x10;
  logic [pgac_pkg::LIM_W-1:0]      limit, width_ext, ticks_ext;
  logic                            near;

  assign pop = q_stat.not_empty && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slew_r  <= pgac_pkg::SLEW_RESET;
      ticks_r <= pgac_pkg::TICKS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pgac_pkg::REG_SLEW_LIMIT:   slew_r  <= cfg_data[pgac_pkg::SLEW_W-1:0];
        pgac_pkg::REG_TICKS_PER_CM: ticks_r <= cfg_data[pgac_pkg::TICKS_W-1:0];
        default: ;
      endcase
    end
  end

  // slew limit, 3-tap average and pair average
  always_comb begin
    s_ext    = pgac_pkg::CMP_W'(job.sample);
    last_ext = pgac_pkg::CMP_W'(last_r);
    slew_ext = pgac_pkg::CMP_W'(slew_r);
    s_lim    = s_ext;
    if (s_ext > last_ext && (s_ext - last_ext) > slew_ext) begin
      s_lim = last_ext + slew_ext;
    end else if (s_ext < last_ext && (last_ext - s_ext) > slew_ext) begin
      s_lim = last_ext - slew_ext;
    end
    s_clamped  = s_lim[SB-1:0];
    sum3       = pgac_pkg::SUM3_W'(s_clamped) + pgac_pkg::SUM3_W'(last_r)
               + pgac_pkg::SUM3_W'(older_r);
    prod       = pgac_pkg::PROD_W'(sum3)
               * pgac_pkg::PROD_W'(pgac_pkg::DIV3_MUL);
    avg        = prod[pgac_pkg::DIV3_SHIFT +: SB];
    pair_total = pair_sum_r + (SB+1)'(avg);
    pavg       = pair_total[SB:1];
  end

  // proximity test
  always_comb begin
    limit     = pgac_pkg::LIM_W'(thresh_r) * pgac_pkg::LIM_W'(ticks_r);
    width_ext = pgac_pkg::LIM_W'(width_r);
    ticks_ext = pgac_pkg::LIM_W'(ticks_r);
    near      = fresh_r && (width_ext > ticks_ext) && (width_ext < limit);
  end

  assign pending_x10 = {pending_r[12:0], 3'b000} + {pending_r[14:0], 1'b0};

  always_comb begin
    last_nxt       = last_r;
    older_nxt      = older_r;
    pair_sum_nxt   = pair_sum_r;
    pair_phase_nxt = pair_phase_r;
    mode_nxt       = mode_r;
    record_nxt     = record_r;
    digits_nxt     = digits_r;
    pending_nxt    = pending_r;
    thresh_nxt     = thresh_r;
    edge_phase_nxt = edge_phase_r;
    rise_nxt       = rise_r;
    width_nxt      = width_r;
    fresh_nxt      = fresh_r;
    led_nxt        = led_r;
    out_data_nxt   = '0;

    unique case (job.kind)
      pgac_pkg::REQ_AUDIO: begin
        older_nxt = last_r;
        last_nxt  = s_clamped;
        if (pair_phase_r) begin
          pair_sum_nxt   = '0;
          pair_phase_nxt = 1'b0;
          if (record_r) begin
            out_data_nxt.audio_valid = 1'b1;
            out_data_nxt.audio_byte  = pavg[SB-1 -: 8];
          end
        end else begin
          pair_sum_nxt   = pair_total;
          pair_phase_nxt = 1'b1;
        end
      end
      pgac_pkg::REQ_CMD: begin
        unique case (job.cmd)
          pgac_pkg::CMD_IDLE, pgac_pkg::CMD_MANUAL: begin
            mode_nxt   = (job.cmd == pgac_pkg::CMD_MANUAL) ? pgac_pkg::OP_MANUAL
                                                           : pgac_pkg::OP_IDLE;
            record_nxt = (job.cmd == pgac_pkg::CMD_MANUAL);
            last_nxt       = pgac_pkg::SAMPLE_MID;
            older_nxt      = pgac_pkg::SAMPLE_MID;
            pair_sum_nxt   = '0;
            pair_phase_nxt = 1'b0;
            digits_nxt     = 1'b0;
            pending_nxt    = '0;
            edge_phase_nxt = 1'b0;
            width_nxt      = pgac_pkg::FAR_WIDTH;
            fresh_nxt      = 1'b0;
          end
          pgac_pkg::CMD_DIST: begin
            mode_nxt       = pgac_pkg::OP_IDLE;
            record_nxt     = 1'b0;
            digits_nxt     = 1'b1;
            pending_nxt    = '0;
            edge_phase_nxt = 1'b0;
            width_nxt      = pgac_pkg::FAR_WIDTH;
            fresh_nxt      = 1'b0;
          end
          pgac_pkg::CMD_DIGIT: begin
            if (digits_r) begin
              pending_nxt = pending_x10 + 16'(job.digit);
            end
          end
          pgac_pkg::CMD_EOL: begin
            if (digits_r) begin
              if (pending_r != '0 && pending_r < 16'(pgac_pkg::MAX_THRESHOLD)) begin
                thresh_nxt = pending_r[pgac_pkg::TH_W-1:0];
              end
              mode_nxt       = pgac_pkg::OP_RANGE;
              record_nxt     = 1'b0;
              edge_phase_nxt = 1'b0;
              width_nxt      = pgac_pkg::FAR_WIDTH;
              fresh_nxt      = 1'b0;
              digits_nxt     = 1'b0;
              pending_nxt    = '0;
            end
          end
          default: ;
        endcase
      end
      pgac_pkg::REQ_EDGE: begin
        if (mode_r == pgac_pkg::OP_RANGE) begin
          if (!edge_phase_r) begin
            rise_nxt       = job.edge_time;
            edge_phase_nxt = 1'b1;
          end else begin
            width_nxt      = job.edge_time - rise_r;
            fresh_nxt      = 1'b1;
            edge_phase_nxt = 1'b0;
          end
        end
      end
      pgac_pkg::REQ_TICK: begin
        if (mode_r == pgac_pkg::OP_RANGE) begin
          record_nxt = near;
          led_nxt    = near;
          fresh_nxt  = 1'b0;
          out_data_nxt.trigger_request = 1'b1;
        end
      end
      default: ;
    endcase

    out_data_nxt.led_on       = led_nxt;
    out_data_nxt.mode_now     = mode_nxt;
    out_data_nxt.recording_on = record_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r       <= pgac_pkg::SAMPLE_MID;
      older_r      <= pgac_pkg::SAMPLE_MID;
      pair_sum_r   <= '0;
      pair_phase_r <= 1'b0;
      mode_r       <= pgac_pkg::OP_IDLE;
      record_r     <= 1'b0;
      digits_r     <= 1'b0;
      pending_r    <= '0;
      thresh_r     <= pgac_pkg::TH_RESET;
      edge_phase_r <= 1'b0;
      rise_r       <= '0;
      width_r      <= pgac_pkg::FAR_WIDTH;
      fresh_r      <= 1'b0;
      led_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (pop) begin
        last_r       <= last_nxt;
        older_r      <= older_nxt;
        pair_sum_r   <= pair_sum_nxt;
        pair_phase_r <= pair_phase_nxt;
        mode_r       <= mode_nxt;
        record_r     <= record_nxt;
        digits_r     <= digits_nxt;
        pending_r    <= pending_nxt;
        thresh_r     <= thresh_nxt;
        edge_phase_r <= edge_phase_nxt;
        rise_r       <= rise_nxt;
        width_r      <= width_nxt;
        fresh_r      <= fresh_nxt;
        led_r        <= led_nxt;
      end
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ rtl/pgac_checker.sv @@
// port-level checker for the proximity gated audio conditioner, with its bind
`include "proximity_gated_audio_conditioner_macros.svh"

module pgac_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input pgac_pkg::out_item_t out_data
);

  `PGAC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")
  `PGAC_ASSERT_NOW(a_byte_needs_rec, out_valid && out_data.audio_valid, out_data.recording_on, "audio byte while not recording")
  `PGAC_ASSERT_NOW(a_byte_zero, out_valid && !out_data.audio_valid, out_data.audio_byte == 8'd0, "audio byte not zero without valid")
  `PGAC_ASSERT_NOW(a_trig_mode, out_valid && out_data.trigger_request, out_data.mode_now == pgac_pkg::OP_RANGE, "trigger outside distance mode")
  `PGAC_ASSERT_NOW(a_manual_rec, out_valid && out_data.mode_now == pgac_pkg::OP_MANUAL, out_data.recording_on, "manual mode without recording")

endmodule

bind proximity_gated_audio_conditioner pgac_checker u_pgac_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
